// File: rtl/fys_pkg.sv
// Shared types and constants for the Fisher-Yates shuffle unit.
// No dependencies; imported by every module of the block.
package fys_pkg;

  localparam int WORD_W    = 32;  // random word width
  localparam int SIZE_W    = 7;   // permutation size register width
  localparam int ELEM_W    = 6;   // width of one permutation entry
  localparam int DIV_CNT_W = $clog2(WORD_W);
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);

  // One command handed from the front end to the table engine.
  typedef struct packed {
    logic              swap;  // perform a swap of part and pos
    logic              emit;  // stream out the table afterwards
    logic [ELEM_W-1:0] part;  // partner index
    logic [ELEM_W-1:0] pos;   // current descending position
  } fys_op_t;

endpackage

// File: rtl/fisher_yates_shuffle_unit.sv
// Top level of the Fisher-Yates shuffle unit: size register, front end,
// command queue and table engine. Depends on fys_pkg and the fys_* modules.
//
// Usage: pulse start with a random word on rand_word while busy is low; the
// word is taken on that edge. Each word performs one descending swap of the
// permutation table. The word that completes the last swap (or any word when
// the size is one) makes the unit stream the whole table: done is high with
// no gaps while the entries of the effective size stream, one entry on element per
// cycle in table order, with last high on the final entry. The table then
// returns to the identity. The receiver cannot stall; results appear whether
// taken or not.
// Flow: after accepting a word the front end runs the 32 steps of the
// bit-serial modulo divider and then hands the command to the queue, so
// busy stays high until the command is pushed (at size one the divider is
// skipped); a full queue holds the front end in that hand-off. The table
// engine performs each swap as pop, read and two writes, then streams the
// table, overlapped with the divider through a two-entry queue, so a new
// word can be taken while earlier swaps are still in the table engine.
// Writing perm_size (cfg_wr_en) aborts any partial shuffle; do so only while
// the unit is idle. Reset sets perm_size to 2 and the table to the identity.
module fisher_yates_shuffle_unit import fys_pkg::*; #(
  parameter int MAX_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [WORD_W-1:0] rand_word,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] perm_size,
  output logic              done,
  output logic [ELEM_W-1:0] element,
  output logic              last
);

  logic [SIZE_W-1:0] size_reg;
  logic [SIZE_W-1:0] n_eff;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  fys_op_t           push_op;
  fys_op_t           q_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg <= SIZE_RESET;
    end else if (cfg_wr_en) begin
      size_reg <= perm_size;
    end
  end

  // A size of zero acts as one; sizes above the table depth saturate.
  always_comb begin
    if (size_reg == '0) begin
      n_eff = SIZE_W'(1);
    end else if (size_reg > SIZE_W'(MAX_SIZE)) begin
      n_eff = SIZE_W'(MAX_SIZE);
    end else begin
      n_eff = size_reg;
    end
  end

  fys_front u_front (
    .clk       (clk),
    .rst       (rst),
    .clr       (cfg_wr_en),
    .start     (start),
    .rand_word (rand_word),
    .n_eff     (n_eff),
    .q_full    (q_full),
    .busy      (busy),
    .push      (push),
    .push_op   (push_op)
  );

  fys_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .q_op    (q_op),
    .full    (q_full),
    .empty   (q_empty)
  );

  fys_back #(
    .MAX_SIZE (MAX_SIZE)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .clr     (cfg_wr_en),
    .n_eff   (n_eff),
    .q_empty (q_empty),
    .q_op    (q_op),
    .pop     (pop),
    .done    (done),
    .element (element),
    .last    (last)
  );

endmodule

// File: rtl/fys_front.sv
// Front end of the shuffle unit: accepts random words, tracks the swap count
// and reduces each word modulo (position + 1) with a bit-serial divider.
// Depends on fys_pkg.
module fys_front import fys_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic              start,
  input  logic [WORD_W-1:0] rand_word,
  input  logic [SIZE_W-1:0] n_eff,
  input  logic              q_full,
  output logic              busy,
  output logic              push,
  output fys_op_t           push_op
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } front_state_t;

  front_state_t         state;
  logic [SIZE_W-2:0]    swaps;
  logic [WORD_W-1:0]    word;
  logic [SIZE_W-1:0]    rem;
  logic [SIZE_W-1:0]    divisor;
  logic [DIV_CNT_W-1:0] cnt;
  fys_op_t              op;

  logic [SIZE_W-1:0]    trial;
  logic [SIZE_W-1:0]    rem_step;
  logic [SIZE_W-2:0]    swap_inc;
  logic                 last_swap;
  logic [SIZE_W-1:0]    pos_full;
  logic                 accept;

  // The remainder stays below the divisor (at most 64), so the shifted
  // trial value always fits in SIZE_W bits.
  assign trial     = {rem[SIZE_W-2:0], word[WORD_W-1]};
  assign rem_step  = (trial >= divisor) ? (trial - divisor) : trial;
  assign swap_inc  = swaps + 1'b1;
  assign last_swap = ({1'b0, swap_inc} == (n_eff - SIZE_W'(1)));
  assign pos_full  = n_eff - SIZE_W'(1) - {1'b0, swaps};
  assign accept    = (state == F_IDLE) && start;

  assign busy    = (state != F_IDLE);
  assign push    = (state == F_PUSH) && !q_full;
  assign push_op = op;

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      state <= F_IDLE;
      swaps <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (start) begin
            if (n_eff == SIZE_W'(1)) begin
              state <= F_PUSH;
            end else begin
              swaps <= last_swap ? '0 : swap_inc;
              cnt   <= '0;
              state <= F_DIV;
            end
          end
        end
        F_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == '1) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (n_eff == SIZE_W'(1)) begin
        op.swap <= 1'b0;
        op.emit <= 1'b1;
        op.part <= '0;
        op.pos  <= '0;
      end else begin
        op.swap <= 1'b1;
        op.emit <= last_swap;
        op.pos  <= ELEM_W'(pos_full);
        divisor <= n_eff - {1'b0, swaps};
        word    <= rand_word;
        rem     <= '0;
      end
    end else if (state == F_DIV) begin
      word <= {word[WORD_W-2:0], 1'b0};
      rem  <= rem_step;
      if (cnt == '1) begin
        op.part <= ELEM_W'(rem_step);
      end
    end
  end

endmodule

// File: rtl/fys_queue.sv
// Two-entry command queue between the front end and the table engine.
// Depends on fys_pkg.
module fys_queue import fys_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  fys_op_t push_op,
  input  logic    pop,
  output fys_op_t q_op,
  output logic    full,
  output logic    empty
);

  fys_op_t           entry [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QDEPTH));
  assign empty = (count == '0);
  assign q_op  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_op;
    end
  end

endmodule

// File: rtl/fys_back.sv
// Table engine of the shuffle unit: holds the permutation table in a
// dual-read memory, performs swaps and streams out the finished table.
// Depends on fys_pkg.
module fys_back import fys_pkg::*; #(
  parameter int MAX_SIZE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clr,
  input  logic [SIZE_W-1:0] n_eff,
  input  logic              q_empty,
  input  fys_op_t           q_op,
  output logic              pop,
  output logic              done,
  output logic [ELEM_W-1:0] element,
  output logic              last
);

  localparam int IDX_W = $clog2(MAX_SIZE);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001,
    B_RD   = 5'b00010,
    B_WR1  = 5'b00100,
    B_WR2  = 5'b01000,
    B_EMIT = 5'b10000
  } back_state_t;

  back_state_t       state;
  fys_op_t           op;
  logic [IDX_W-1:0]  k;
  logic              out_pend;
  logic              out_last;

  logic [ELEM_W-1:0] mem [MAX_SIZE];
  // An entry whose bit is clear holds its own index.
  logic [MAX_SIZE-1:0] vld;

  logic [ELEM_W-1:0] rd_a;
  logic [ELEM_W-1:0] rd_b;
  logic              rd_a_v;
  logic              rd_b_v;
  logic [IDX_W-1:0]  rd_a_addr;
  logic [IDX_W-1:0]  rd_b_addr;

  logic [IDX_W-1:0]  part_a;
  logic [IDX_W-1:0]  pos_a;
  logic [IDX_W-1:0]  ra_a;
  logic              rd_en;
  logic              k_last;
  logic [ELEM_W-1:0] val_a;
  logic [ELEM_W-1:0] val_b;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  logic [ELEM_W-1:0] mem_wd;

  assign part_a = op.part[IDX_W-1:0];
  assign pos_a  = op.pos[IDX_W-1:0];
  assign ra_a   = (state == B_EMIT) ? k : part_a;
  assign rd_en  = (state == B_RD) || (state == B_EMIT);
  assign k_last = (SIZE_W'(k) == (n_eff - SIZE_W'(1)));
  assign pop    = (state == B_IDLE) && !q_empty;

  assign val_a = rd_a_v ? rd_a : ELEM_W'(rd_a_addr);
  assign val_b = rd_b_v ? rd_b : ELEM_W'(rd_b_addr);

  assign mem_we = (state == B_WR1) || (state == B_WR2);
  assign mem_wa = (state == B_WR1) ? part_a : pos_a;
  assign mem_wd = (state == B_WR1) ? val_b : val_a;

  assign done    = out_pend;
  assign last    = out_pend && out_last;
  assign element = val_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      out_pend <= 1'b0;
      k        <= '0;
      vld      <= '0;
    end else begin
      out_pend <= 1'b0;
      if (clr) begin
        vld <= '0;
      end
      case (state)
        B_IDLE: begin
          k <= '0;
          if (!q_empty) begin
            state <= q_op.swap ? B_RD : B_EMIT;
          end
        end
        B_RD: begin
          state <= B_WR1;
        end
        B_WR1: begin
          vld[part_a] <= 1'b1;
          state       <= B_WR2;
        end
        B_WR2: begin
          vld[pos_a] <= 1'b1;
          k          <= '0;
          state      <= op.emit ? B_EMIT : B_IDLE;
        end
        B_EMIT: begin
          out_pend <= 1'b1;
          k        <= k + 1'b1;
          // The last read samples the old table on this same edge, so the table
          // can return to the identity here.
          if (k_last) begin
            vld   <= '0;
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      op <= q_op;
    end
    if (state == B_EMIT) begin
      out_last <= k_last;
    end
    if (rd_en) begin
      rd_a_v    <= vld[ra_a];
      rd_b_v    <= vld[pos_a];
      rd_a_addr <= ra_a;
      rd_b_addr <= pos_a;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_a <= mem[ra_a];
      rd_b <= mem[pos_a];
    end
  end

endmodule

// File: rtl/fys_checker.sv
// Port-level checks for the Fisher-Yates shuffle unit, bound to the top level.
// Depends on fys_pkg.
module fys_checker import fys_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [ELEM_W-1:0] element,
  input logic              last
);

  // An accepted transaction always occupies the front end for a while.
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst) (start && !busy) |=> busy
  ) else $error("busy not raised after an accepted transaction");

  a_last_with_done: assert property (
    @(posedge clk) disable iff (rst) last |-> done
  ) else $error("last raised without done");

  // The table streams out without gaps until its final entry.
  a_stream_contiguous: assert property (
    @(posedge clk) disable iff (rst) (done && !last) |=> done
  ) else $error("gap in the permutation stream");

  a_quiet_after_reset: assert property (
    @(posedge clk) rst |=> !done
  ) else $error("result strobe right after reset");

endmodule

bind fisher_yates_shuffle_unit fys_checker u_fys_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .element (element),
  .last    (last)
);
